// ===== rtl/core/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int DEF_RING_ENTRIES = 16;

	localparam int CMD_W    = 2;
	localparam int PAGE_W   = 27;
	localparam int STATUS_W = 3;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_REFERENCE = 2'd1,
		CMD_VICTIM    = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_ABSENT    = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef logic [PAGE_W-1:0] page_t;

endpackage

// ===== rtl/core/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance (clock) page replacement over a linked ring of resident pages.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while the
// sequencer is idle, and one response is produced for every request. Insert
// and reference walk the page store one slot at a time through its single
// read port, with a read state and a compare state per slot; an insert that
// links a new page then passes through a link read state and two link write
// states. A victim request walks the ring backward through the link RAMs,
// reading one link per referenced page passed over, then unlinks the victim;
// the walk is bounded by 2*(RING_ENTRIES+1)+2 steps. The response sits in an
// output register, so a finished response may wait while the block is idle.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
	parameter int RING_ENTRIES = cpr_pkg::DEF_RING_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [1:0] command, [28:2] page_number
	input  logic [cpr_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [2:0] status, [29:3] victim_page
	output logic [cpr_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	import cpr_pkg::*;

	localparam int NODE_W   = $clog2(RING_ENTRIES + 1);
	localparam int SLOT_W   = $clog2(RING_ENTRIES);
	localparam int STEP_LIM = 2 * (RING_ENTRIES + 1) + 2;
	localparam int STEP_W   = $clog2(STEP_LIM + 1);

	localparam logic [NODE_W-1:0] SENT     = NODE_W'(RING_ENTRIES);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(RING_ENTRIES - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_END,
		S_INS_RD,
		S_INS_W1,
		S_INS_W2,
		S_V_START,
		S_V_CHK,
		S_V_RD,
		S_V_UNLINK,
		S_FIN
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	page_t                   page_q;
	logic [RING_ENTRIES-1:0] valid_q;
	logic [RING_ENTRIES-1:0] ref_q;
	logic [NODE_W-1:0]       sent_fwd_q;
	logic [NODE_W-1:0]       sent_bwd_q;
	logic [NODE_W-1:0]       hand_q;
	logic [NODE_W-1:0]       cur_q;
	logic [NODE_W-1:0]       nx_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [SLOT_W-1:0]       hit_idx_q;
	logic                    hit_q;
	logic [SLOT_W-1:0]       free_idx_q;
	logic                    free_q;
	logic [SLOT_W-1:0]       vic_q;
	logic [STEP_W-1:0]       step_q;
	status_t                 res_status_q;
	page_t                   res_victim_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	page_t                   out_victim_q;

	logic              page_we;
	logic [SLOT_W-1:0] page_raddr;
	page_t             page_rdata;
	logic              fwd_we;
	logic [SLOT_W-1:0] fwd_waddr;
	logic [NODE_W-1:0] fwd_wdata;
	logic [NODE_W-1:0] fwd_rdata;
	logic              bwd_we;
	logic [SLOT_W-1:0] bwd_waddr;
	logic [NODE_W-1:0] bwd_wdata;
	logic [NODE_W-1:0] bwd_rdata;
	logic [SLOT_W-1:0] link_raddr;

	logic [NODE_W-1:0] h2;
	logic [NODE_W-1:0] ins_nx;
	logic [NODE_W-1:0] free_node;
	logic              out_free;

	assign h2        = (cur_q == SENT) ? sent_bwd_q : cur_q;
	assign ins_nx    = (hand_q == SENT) ? sent_fwd_q : fwd_rdata;
	assign free_node = NODE_W'(free_idx_q);
	assign out_free  = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - STATUS_W - PAGE_W){1'b0}}, out_victim_q, out_status_q};

	// read address and write port steering
	always_comb begin
		page_raddr = (state_q == S_V_CHK) ? h2[SLOT_W-1:0] : idx_q;
		link_raddr = (state_q == S_V_CHK) ? h2[SLOT_W-1:0] : hand_q[SLOT_W-1:0];
		page_we    = (state_q == S_INS_W1);
		fwd_we     = 1'b0;
		fwd_waddr  = free_idx_q;
		fwd_wdata  = nx_q;
		bwd_we     = 1'b0;
		bwd_waddr  = free_idx_q;
		bwd_wdata  = hand_q;
		case (state_q)
			S_INS_W1: begin
				fwd_we    = 1'b1;
				fwd_wdata = ins_nx;
				bwd_we    = 1'b1;
			end
			S_INS_W2: begin
				fwd_we    = (hand_q != SENT);
				fwd_waddr = hand_q[SLOT_W-1:0];
				fwd_wdata = free_node;
				bwd_we    = (nx_q != SENT);
				bwd_waddr = nx_q[SLOT_W-1:0];
				bwd_wdata = free_node;
			end
			S_V_UNLINK: begin
				fwd_we    = (bwd_rdata != SENT);
				fwd_waddr = bwd_rdata[SLOT_W-1:0];
				fwd_wdata = fwd_rdata;
				bwd_we    = (fwd_rdata != SENT);
				bwd_waddr = fwd_rdata[SLOT_W-1:0];
				bwd_wdata = bwd_rdata;
			end
			default: begin
			end
		endcase
	end

	cpr_ram #(.WIDTH(PAGE_W), .DEPTH(RING_ENTRIES)) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (free_idx_q),
		.wdata (page_q),
		.raddr (page_raddr),
		.rdata (page_rdata)
	);

	cpr_ram #(.WIDTH(NODE_W), .DEPTH(RING_ENTRIES)) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_waddr),
		.wdata (fwd_wdata),
		.raddr (link_raddr),
		.rdata (fwd_rdata)
	);

	cpr_ram #(.WIDTH(NODE_W), .DEPTH(RING_ENTRIES)) u_bwd_ram (
		.clk   (clk),
		.we    (bwd_we),
		.waddr (bwd_waddr),
		.wdata (bwd_wdata),
		.raddr (link_raddr),
		.rdata (bwd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			ref_q        <= '0;
			sent_fwd_q   <= SENT;
			sent_bwd_q   <= SENT;
			hand_q       <= SENT;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_INSERT;
			page_q       <= '0;
			cur_q        <= SENT;
			nx_q         <= SENT;
			idx_q        <= '0;
			hit_idx_q    <= '0;
			hit_q        <= 1'b0;
			free_idx_q   <= '0;
			free_q       <= 1'b0;
			vic_q        <= '0;
			step_q       <= '0;
			res_status_q <= ST_OK;
			res_victim_q <= '0;
			out_status_q <= ST_OK;
			out_victim_q <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q        <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
						page_q       <= s_axis_tdata[CMD_W +: PAGE_W];
						idx_q        <= '0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						res_status_q <= ST_OK;
						res_victim_q <= '0;
						case (s_axis_tdata[CMD_W-1:0])
							CMD_INSERT, CMD_REFERENCE: state_q <= S_SCAN_RD;
							CMD_VICTIM:                state_q <= S_V_START;
							default:                   state_q <= S_FIN;
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (valid_q[idx_q] && page_rdata == page_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!valid_q[idx_q] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_SCAN_END;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_END: begin
					if (cmd_q == CMD_REFERENCE) begin
						if (hit_q) begin
							ref_q[hit_idx_q] <= 1'b1;
						end else begin
							res_status_q <= ST_ABSENT;
						end
						state_q <= S_FIN;
					end else if (hit_q) begin
						res_status_q <= ST_DUPLICATE;
						state_q      <= S_FIN;
					end else if (!free_q) begin
						res_status_q <= ST_FULL;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_W1;
				end
				S_INS_W1: begin
					nx_q                <= ins_nx;
					valid_q[free_idx_q] <= 1'b1;
					ref_q[free_idx_q]   <= 1'b0;
					state_q             <= S_INS_W2;
				end
				S_INS_W2: begin
					if (hand_q == SENT) begin
						sent_fwd_q <= free_node;
					end
					if (nx_q == SENT) begin
						sent_bwd_q <= free_node;
					end
					state_q <= S_FIN;
				end
				S_V_START: begin
					cur_q  <= hand_q;
					step_q <= '0;
					if (hand_q == SENT && sent_bwd_q == SENT) begin
						res_status_q <= ST_EMPTY;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_V_CHK;
					end
				end
				S_V_CHK: begin
					if (step_q == STEP_W'(STEP_LIM)) begin
						hand_q       <= cur_q;
						res_status_q <= ST_EMPTY;
						state_q      <= S_FIN;
					end else if (h2 == SENT) begin
						hand_q       <= SENT;
						res_status_q <= ST_EMPTY;
						state_q      <= S_FIN;
					end else if (!ref_q[h2[SLOT_W-1:0]]) begin
						vic_q   <= h2[SLOT_W-1:0];
						state_q <= S_V_UNLINK;
					end else begin
						ref_q[h2[SLOT_W-1:0]] <= 1'b0;
						state_q               <= S_V_RD;
					end
				end
				S_V_RD: begin
					cur_q   <= bwd_rdata;
					step_q  <= step_q + 1'b1;
					state_q <= S_V_CHK;
				end
				S_V_UNLINK: begin
					if (bwd_rdata == SENT) begin
						sent_fwd_q <= fwd_rdata;
					end
					if (fwd_rdata == SENT) begin
						sent_bwd_q <= bwd_rdata;
					end
					valid_q[vic_q] <= 1'b0;
					ref_q[vic_q]   <= 1'b0;
					hand_q         <= bwd_rdata;
					res_victim_q   <= page_rdata;
					state_q        <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_victim_q <= res_victim_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// empty ring: both sentinel links point home, and no slot is resident
	a_sent_links_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((sent_fwd_q == SENT) == (sent_bwd_q == SENT)))
		else $error("sentinel links disagree on empty ring");

	a_empty_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((sent_fwd_q == SENT) == (valid_q == '0)))
		else $error("ring emptiness does not match slot valid bits");

	a_hand_resident: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && hand_q != SENT) |-> valid_q[hand_q[SLOT_W-1:0]])
		else $error("hand rests on a free slot");

	a_victim_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_victim_q == '0))
		else $error("victim page set on a failed request");

endmodule

// ===== rtl/core/cpr_ram.sv =====
// ----------------------------------------------------------------------------
// cpr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== verif/tb_clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_clock_page_replacement
// Self-checking bench for the second-chance page replacement ring. A short
// table of requests covers the empty, full, absent, duplicate and unused
// command cases and the second-chance sweep. Random traffic follows, in
// fill, mixed and drain phases over a small pool of pages. Every response is
// compared with a behavioral ring copy or with a table row's fixed result.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement;
	import cpr_pkg::*;

	localparam int RING         = DEF_RING_ENTRIES;
	localparam int NODE_W       = $clog2(RING + 1);
	localparam int WALK_LIMIT   = 2 * (RING + 1) + 2;
	localparam int RANDOM_ITEMS = 1400;
	localparam int POOL_SIZE    = 32;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 4000;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam page_t PAGE_ONES = '1;

	typedef logic [NODE_W-1:0] node_t;
	localparam node_t SENTINEL = node_t'(RING);

	typedef struct packed {
		status_t status;
		page_t   victim;
	} reply_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		page_t            page;
		bit               fixed;
		status_t          status;
		page_t            victim;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// bench copy of the ring
	page_t ring_page [RING];
	logic  ring_valid [RING];
	logic  ring_ref [RING];
	node_t link_fwd [RING+1];
	node_t link_bwd [RING+1];
	node_t ring_hand;

	reply_t        replies_due[$];
	reply_t        oldest_reply;
	directed_row_t directed_rows[$];
	page_t         page_pool [POOL_SIZE];
	int            error_count = 0;
	int            burst_left = 1;
	int            idle_cycles = 0;
	bit            long_hold_req = 1'b0;

	clock_page_replacement #(
		.RING_ENTRIES(RING)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void predict_ring_op(input logic [CMD_W-1:0] cmd, input page_t pg,
			output status_t st, output page_t vp);
		int    i;
		int    hit;
		int    free_slot;
		int    step;
		bit    done;
		node_t h;
		node_t pv;
		node_t nx;
		st = ST_OK;
		vp = '0;
		hit = -1;
		free_slot = -1;
		done = 1'b0;
		for (i = 0; i < RING; i++) begin
			if (hit < 0 && ring_valid[i] && ring_page[i] == pg)
				hit = i;
			if (free_slot < 0 && !ring_valid[i])
				free_slot = i;
		end
		case (cmd)
			CMD_INSERT: begin
				if (hit >= 0) begin
					st = ST_DUPLICATE;
				end else if (free_slot < 0) begin
					st = ST_FULL;
				end else begin
					h = ring_hand;
					nx = link_fwd[h];
					ring_page[free_slot] = pg;
					ring_valid[free_slot] = 1'b1;
					ring_ref[free_slot] = 1'b0;
					link_fwd[free_slot] = nx;
					link_bwd[free_slot] = h;
					link_fwd[h] = node_t'(free_slot);
					link_bwd[nx] = node_t'(free_slot);
				end
			end
			CMD_REFERENCE: begin
				if (hit < 0)
					st = ST_ABSENT;
				else
					ring_ref[hit] = 1'b1;
			end
			CMD_VICTIM: begin
				h = ring_hand;
				st = ST_EMPTY;
				for (step = 0; step < WALK_LIMIT && !done; step++) begin
					if (h == SENTINEL)
						h = link_bwd[SENTINEL];
					if (h == SENTINEL) begin
						done = 1'b1;
					end else if (!ring_ref[h]) begin
						pv = link_bwd[h];
						nx = link_fwd[h];
						link_fwd[pv] = nx;
						link_bwd[nx] = pv;
						ring_valid[h] = 1'b0;
						ring_ref[h] = 1'b0;
						st = ST_OK;
						vp = ring_page[h];
						h = pv;
						done = 1'b1;
					end else begin
						// second chance
						ring_ref[h] = 1'b0;
						h = link_bwd[h];
					end
				end
				ring_hand = h;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic add_row(input logic [CMD_W-1:0] cmd, input page_t page, input bit fixed = 1'b0,
			input status_t st = ST_OK, input page_t vp = '0);
		directed_row_t row;
		row.cmd = cmd;
		row.page = page;
		row.fixed = fixed;
		row.status = st;
		row.victim = vp;
		directed_rows.push_back(row);
	endtask

	task automatic issue_request(input logic [CMD_W-1:0] cmd, input page_t page,
			input bit fixed, input status_t fixed_status, input page_t fixed_victim);
		status_t st;
		page_t   vp;
		reply_t  reply;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W-CMD_W-PAGE_W){1'b0}}, page, cmd};
		do @(posedge clk); while (!s_axis_tready);
		predict_ring_op(cmd, page, st, vp);
		reply.status = fixed ? fixed_status : st;
		reply.victim = fixed ? fixed_victim : vp;
		replies_due.push_back(reply);
	endtask

	// bursts of requests with random gaps; drain waits for every response
	task automatic pace_sender(input bit drain);
		burst_left--;
		if (drain || burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			if (drain) begin
				while (replies_due.size() != 0)
					@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unrequested response", m_axis_tdata, '0);
			end else begin
				oldest_reply = replies_due.pop_front();
				if (m_axis_tdata[STATUS_W-1:0] !== oldest_reply.status)
					report_mismatch("status", 32'(m_axis_tdata[STATUS_W-1:0]),
						32'(oldest_reply.status));
				if (m_axis_tdata[STATUS_W +: PAGE_W] !== oldest_reply.victim)
					report_mismatch("victim_page", 32'(m_axis_tdata[STATUS_W +: PAGE_W]),
						32'(oldest_reply.victim));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("tb_clock_page_replacement: done, errors");
				$finish;
			end
		end
	end

	// response side: stall patterns of random length, one long hold on demand
	initial begin
		int stretch;
		int pattern;
		stretch = 0;
		pattern = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					pattern = $urandom_range(0, 2);
					stretch = $urandom_range(16, 96);
				end
				stretch--;
				case (pattern)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int      k;
		int      n;
		int      mode;
		int      pick;
		logic [CMD_W-1:0] cmd;
		page_t   page;
		for (k = 0; k < RING; k++) begin
			ring_page[k] = '0;
			ring_valid[k] = 1'b0;
			ring_ref[k] = 1'b0;
		end
		for (k = 0; k <= RING; k++) begin
			link_fwd[k] = SENTINEL;
			link_bwd[k] = SENTINEL;
		end
		ring_hand = SENTINEL;
		for (k = 0; k < POOL_SIZE; k++)
			page_pool[k] = PAGE_W'($urandom);
		page_pool[0] = '0;
		page_pool[1] = PAGE_ONES;

		add_row(CMD_VICTIM, '0, 1'b1, ST_EMPTY, '0);
		add_row(CMD_REFERENCE, '0, 1'b1, ST_ABSENT, '0);
		add_row(CMD_UNUSED, PAGE_ONES, 1'b1, ST_OK, '0);
		add_row(CMD_INSERT, '0);
		add_row(CMD_INSERT, '0, 1'b1, ST_DUPLICATE, '0);
		add_row(CMD_INSERT, PAGE_ONES);
		add_row(CMD_REFERENCE, PAGE_ONES);
		add_row(CMD_VICTIM, PAGE_ONES);
		add_row(CMD_VICTIM, '0);
		add_row(CMD_VICTIM, '0, 1'b1, ST_EMPTY, '0);
		for (k = 0; k < RING; k++)
			add_row(CMD_INSERT, ((k % 2) ? 27'h5555555 : 27'h2AAAAAA) ^ PAGE_W'(k));
		add_row(CMD_INSERT, 27'h1234567, 1'b1, ST_FULL, '0);
		// duplicate check wins over full
		add_row(CMD_INSERT, 27'h2AAAAAA, 1'b1, ST_DUPLICATE, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < directed_rows.size(); k++) begin
			issue_request(directed_rows[k].cmd, directed_rows[k].page, directed_rows[k].fixed,
				directed_rows[k].status, directed_rows[k].victim);
			pace_sender(k == directed_rows.size() - 1);
		end

		mode = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				mode = $urandom_range(0, 2);
			if (n == 300)
				long_hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			case (mode)
				0: cmd = (pick < 70) ? CMD_INSERT : (pick < 85) ? CMD_REFERENCE
					: (pick < 97) ? CMD_VICTIM : CMD_UNUSED;
				1: cmd = (pick < 35) ? CMD_INSERT : (pick < 75) ? CMD_REFERENCE
					: (pick < 97) ? CMD_VICTIM : CMD_UNUSED;
				default: cmd = (pick < 15) ? CMD_INSERT : (pick < 40) ? CMD_REFERENCE
					: (pick < 97) ? CMD_VICTIM : CMD_UNUSED;
			endcase
			if ($urandom_range(0, 99) < 85)
				page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				page = PAGE_W'($urandom);
			issue_request(cmd, page, 1'b0, ST_OK, '0);
			pace_sender(n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS - 1);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_clock_page_replacement: done, clean");
		else
			$display("tb_clock_page_replacement: done, errors");
		$finish;
	end

endmodule

// ===== clock_page_replacement.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_ram.sv
rtl/core/clock_page_replacement.sv
verif/tb_clock_page_replacement.sv
